FILE: sv/mpfd_pkg.sv
// ----------------------------------------------------------------------------
// mpfd_pkg: shared definitions for the monochrome page frame draw unit
// Field widths, operation codes, default display sizes and the sequencer
// state type used by the draw unit and its channel interfaces.
// ----------------------------------------------------------------------------
package mpfd_pkg;

    localparam int OP_W    = 3;
    localparam int COORD_W = 8;
    localparam int BADDR_W = 13;
    localparam int DATA_W  = 8;
    localparam int PAGE_W  = 5;

    localparam int DISP_WIDTH_DEF  = 240;
    localparam int DISP_HEIGHT_DEF = 160;

    localparam logic [OP_W-1:0] OP_PIXEL   = 3'd0;
    localparam logic [OP_W-1:0] OP_HLINE   = 3'd1;
    localparam logic [OP_W-1:0] OP_VLINE   = 3'd2;
    localparam logic [OP_W-1:0] OP_OUTLINE = 3'd3;
    localparam logic [OP_W-1:0] OP_FILL    = 3'd4;
    localparam logic [OP_W-1:0] OP_READ    = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RD_REQ,
        ST_RD_RESP
    } state_t;

endpackage

FILE: sv/mpfd_cmd_if.sv
// ----------------------------------------------------------------------------
// mpfd_cmd_if: command channel of the draw unit
// Valid/ready channel that carries one drawing or readout command per item.
// ----------------------------------------------------------------------------
interface mpfd_cmd_if;

    logic                                valid;
    logic                                ready;
    logic [mpfd_pkg::OP_W-1:0]           operation;
    logic [mpfd_pkg::COORD_W-1:0]        x_pos;
    logic [mpfd_pkg::COORD_W-1:0]        y_pos;
    logic [mpfd_pkg::COORD_W-1:0]        length;
    logic [mpfd_pkg::COORD_W-1:0]        height;
    logic [mpfd_pkg::BADDR_W-1:0]        byte_address;

    modport source (
        output valid, operation, x_pos, y_pos, length, height, byte_address,
        input  ready
    );

    modport sink (
        input  valid, operation, x_pos, y_pos, length, height, byte_address,
        output ready
    );

endinterface

FILE: sv/mpfd_rsp_if.sv
// ----------------------------------------------------------------------------
// mpfd_rsp_if: readout channel of the draw unit
// Valid/ready channel that carries one frame store byte per item.
// ----------------------------------------------------------------------------
interface mpfd_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [mpfd_pkg::DATA_W-1:0]  read_data;

    modport source (
        output valid, read_data,
        input  ready
    );

    modport sink (
        input  valid, read_data,
        output ready
    );

endinterface

FILE: sv/mpfd_ram.sv
// ----------------------------------------------------------------------------
// mpfd_ram: generic single-clock RAM
// One write port and one read port, with a registered read.
// ----------------------------------------------------------------------------
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4800,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/mono_page_framebuffer_draw_unit.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_unit: page-organized 1-bit frame store drawing
// Draws pixels, lines and rectangles into a frame store of 8-row pages by
// OR-ing bits, and reads and clears single store bytes for display readout.
// ----------------------------------------------------------------------------
// Each drawing item is split into up to four clipped rectangles; each one
// passes a setup state, then a read and a write state per touched store byte,
// since every byte is a read-modify-write through the single RAM read and
// write port. A read-and-clear item returns its byte and clears it once the
// readout channel is free. After reset a clearing pass zeroes all store bytes,
// DISP_WIDTH * ceil(DISP_HEIGHT / 8) (4800 by default), before the first item.
module mono_page_framebuffer_draw_unit #(
    parameter int DISP_WIDTH  = mpfd_pkg::DISP_WIDTH_DEF,
    parameter int DISP_HEIGHT = mpfd_pkg::DISP_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mpfd_cmd_if.sink   cmd,
    mpfd_rsp_if.source rsp
);

    localparam int PAGE_COUNT  = (DISP_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISP_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    mpfd_pkg::state_t state_reg, state_next;

    logic [mpfd_pkg::OP_W-1:0]    op_reg;
    logic [mpfd_pkg::COORD_W-1:0] x_reg, y_reg, len_reg, hgt_reg;
    logic [mpfd_pkg::BADDR_W-1:0] baddr_reg;
    logic [1:0]                   idx_reg, idx_next;
    logic [ADDR_W-1:0]            clr_reg, clr_next;

    logic [7:0]                   col_reg, col_next;
    logic [7:0]                   col_first_reg, col_first_next;
    logic [7:0]                   col_last_reg, col_last_next;
    logic [7:0]                   row_first_reg, row_first_next;
    logic [7:0]                   row_last_reg, row_last_next;
    logic [mpfd_pkg::PAGE_W-1:0]  page_reg, page_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [mpfd_pkg::DATA_W-1:0]  rsp_data_reg, rsp_data_next;

    logic [8:0]  rx, rw, ry, rh;
    logic [9:0]  col_end, row_end, col_lim, row_lim;
    logic        rect_empty;
    logic        rect_last;
    logic        col_at_end;
    logic        page_at_end;
    logic        out_free;
    logic        in_range;
    logic [2:0]  mask_lo, mask_hi;
    logic [7:0]  rmw_mask;
    logic [ADDR_W-1:0] addr_cur;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [mpfd_pkg::DATA_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [mpfd_pkg::DATA_W-1:0] ram_rdata;

    mpfd_ram #(
        .WIDTH (mpfd_pkg::DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Rectangle selection for the current step of the item.
    always_comb
    begin
        rx = {1'b0, x_reg};
        rw = 9'd1;
        ry = {1'b0, y_reg};
        rh = 9'd1;
        case (op_reg)
            mpfd_pkg::OP_HLINE:
            begin
                rw = {1'b0, len_reg};
            end
            mpfd_pkg::OP_VLINE:
            begin
                rh = {1'b0, len_reg};
            end
            mpfd_pkg::OP_FILL:
            begin
                rw = {1'b0, len_reg};
                rh = {1'b0, hgt_reg};
            end
            mpfd_pkg::OP_OUTLINE:
            begin
                case (idx_reg)
                    2'd0:
                    begin
                        rw = {1'b0, len_reg};
                    end
                    2'd1:
                    begin
                        rh = {1'b0, hgt_reg};
                    end
                    2'd2:
                    begin
                        rw = {1'b0, len_reg};
                        ry = {1'b0, y_reg} + {1'b0, hgt_reg};
                    end
                    default:
                    begin
                        rx = {1'b0, x_reg} + {1'b0, len_reg};
                        rh = {1'b0, hgt_reg} + 9'd1;
                    end
                endcase
            end
            default:
            begin
                rw = 9'd1;
            end
        endcase
    end

    always_comb
    begin
        col_end    = {1'b0, rx} + {1'b0, rw};
        row_end    = {1'b0, ry} + {1'b0, rh};
        col_lim    = (col_end > 10'(DISP_WIDTH)) ? 10'(DISP_WIDTH) : col_end;
        row_lim    = (row_end > 10'(DISP_HEIGHT)) ? 10'(DISP_HEIGHT) : row_end;
        rect_empty = ({1'b0, rx} >= col_lim) || ({1'b0, ry} >= row_lim);
        rect_last  = (op_reg != mpfd_pkg::OP_OUTLINE) || (idx_reg == 2'd3);
    end

    always_comb
    begin
        col_at_end  = (col_reg == col_last_reg);
        page_at_end = (page_reg == row_last_reg[7:3]);
        mask_lo     = (page_reg == row_first_reg[7:3]) ? row_first_reg[2:0] : 3'd0;
        mask_hi     = page_at_end ? row_last_reg[2:0] : 3'd7;
        rmw_mask    = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
        addr_cur    = ADDR_W'(32'(page_reg) * DISP_WIDTH + 32'(col_reg));
        in_range    = (32'(baddr_reg) < STORE_BYTES);
        out_free    = !rsp_valid_reg || rsp.ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpfd_pkg::ST_CLEAR:
            begin
                if (32'(clr_reg) == STORE_BYTES - 1)
                begin
                    state_next = mpfd_pkg::ST_IDLE;
                end
            end
            mpfd_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.operation)
                        mpfd_pkg::OP_PIXEL, mpfd_pkg::OP_HLINE, mpfd_pkg::OP_VLINE,
                        mpfd_pkg::OP_OUTLINE, mpfd_pkg::OP_FILL:
                        begin
                            state_next = mpfd_pkg::ST_SETUP;
                        end
                        mpfd_pkg::OP_READ:
                        begin
                            state_next = mpfd_pkg::ST_RD_REQ;
                        end
                        default:
                        begin
                            state_next = mpfd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mpfd_pkg::ST_SETUP:
            begin
                if (!rect_empty)
                begin
                    state_next = mpfd_pkg::ST_RMW_RD;
                end
                else if (rect_last)
                begin
                    state_next = mpfd_pkg::ST_IDLE;
                end
            end
            mpfd_pkg::ST_RMW_RD:
            begin
                state_next = mpfd_pkg::ST_RMW_WR;
            end
            mpfd_pkg::ST_RMW_WR:
            begin
                if (col_at_end && page_at_end)
                begin
                    state_next = rect_last ? mpfd_pkg::ST_IDLE : mpfd_pkg::ST_SETUP;
                end
                else
                begin
                    state_next = mpfd_pkg::ST_RMW_RD;
                end
            end
            mpfd_pkg::ST_RD_REQ:
            begin
                state_next = mpfd_pkg::ST_RD_RESP;
            end
            mpfd_pkg::ST_RD_RESP:
            begin
                if (out_free)
                begin
                    state_next = mpfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpfd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        cmd.ready      = 1'b0;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        col_first_next = col_first_reg;
        col_last_next  = col_last_reg;
        row_first_next = row_first_reg;
        row_last_next  = row_last_reg;
        page_next      = page_reg;
        rsp_valid_next = rsp.ready ? 1'b0 : rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_cur;
        ram_wdata      = ram_rdata | rmw_mask;
        ram_re         = 1'b0;
        ram_raddr      = addr_cur;
        case (state_reg)
            mpfd_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            mpfd_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                idx_next  = 2'd0;
            end
            mpfd_pkg::ST_SETUP:
            begin
                col_first_next = rx[7:0];
                col_next       = rx[7:0];
                col_last_next  = 8'(col_lim - 10'd1);
                row_first_next = ry[7:0];
                row_last_next  = 8'(row_lim - 10'd1);
                page_next      = ry[7:3];
                if (rect_empty)
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            mpfd_pkg::ST_RMW_RD:
            begin
                ram_re = 1'b1;
            end
            mpfd_pkg::ST_RMW_WR:
            begin
                ram_we = 1'b1;
                if (col_at_end)
                begin
                    col_next = col_first_reg;
                    if (page_at_end)
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                    else
                    begin
                        page_next = page_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 8'd1;
                end
            end
            mpfd_pkg::ST_RD_REQ:
            begin
                ram_re    = 1'b1;
                ram_raddr = baddr_reg[ADDR_W-1:0];
            end
            mpfd_pkg::ST_RD_RESP:
            begin
                ram_waddr = baddr_reg[ADDR_W-1:0];
                ram_wdata = '0;
                if (out_free)
                begin
                    ram_we         = in_range;
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = in_range ? ram_rdata : '0;
                end
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpfd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg    <= cmd.operation;
            x_reg     <= cmd.x_pos;
            y_reg     <= cmd.y_pos;
            len_reg   <= cmd.length;
            hgt_reg   <= cmd.height;
            baddr_reg <= cmd.byte_address;
        end
        col_reg       <= col_next;
        col_first_reg <= col_first_next;
        col_last_reg  <= col_last_next;
        row_first_reg <= row_first_next;
        row_last_reg  <= row_last_next;
        page_reg      <= page_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

`ifndef ASSERT_OFF
    a_rmw_same_byte: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mpfd_pkg::ST_RMW_WR |-> ram_waddr == $past(ram_raddr))
        else $error("Read-modify-write targets a different byte than was read.");

    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mpfd_pkg::ST_RMW_WR |-> rmw_mask != 8'h00)
        else $error("Read-modify-write with an empty pixel mask.");

    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpfd_pkg::ST_RMW_RD || state_reg == mpfd_pkg::ST_RMW_WR)
        |-> (col_reg <= col_last_reg) && (page_reg <= row_last_reg[7:3])
            && (32'(col_reg) < DISP_WIDTH))
        else $error("Rectangle walk left its clipped bounds.");

    a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == mpfd_pkg::ST_CLEAR && state_reg == mpfd_pkg::ST_CLEAR
        |-> !rsp.valid)
        else $error("Result produced during the clearing pass.");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the monochrome page frame draw unit
// Sends pixel, line, rectangle and readout commands through the command
// channel, keeps its own image of the page-organized frame store, and checks
// every byte returned on the readout channel against that image, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCREEN_W    = mpfd_pkg::DISP_WIDTH_DEF;
    localparam int SCREEN_H    = mpfd_pkg::DISP_HEIGHT_DEF;
    localparam int PAGE_ROWS   = 8;
    localparam int PAGES       = (SCREEN_H + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = SCREEN_W * PAGES;
    localparam int ADDR_MAX    = (1 << mpfd_pkg::BADDR_W) - 1;

    localparam logic [mpfd_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [mpfd_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1525;
    localparam int STALL_LIMIT  = 60000;
    localparam int TAIL_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [mpfd_pkg::OP_W-1:0]    operation;
        logic [mpfd_pkg::COORD_W-1:0] x_pos;
        logic [mpfd_pkg::COORD_W-1:0] y_pos;
        logic [mpfd_pkg::COORD_W-1:0] length;
        logic [mpfd_pkg::COORD_W-1:0] height;
        logic [mpfd_pkg::BADDR_W-1:0] byte_address;
    } draw_cmd_t;

    logic clk;
    logic rst_n;

    mpfd_cmd_if cmd_ch ();
    mpfd_rsp_if rsp_ch ();

    mono_page_framebuffer_draw_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    logic [mpfd_pkg::DATA_W-1:0] frame_image [STORE_BYTES];
    logic [mpfd_pkg::DATA_W-1:0] readout_bytes_due [$];
    draw_cmd_t                   pending_cmds [$];
    draw_cmd_t                   next_cmd;
    draw_cmd_t                   taken_cmd;
    logic                        cmd_taken;
    logic                        steady_phase;
    int unsigned                 send_pause;
    int unsigned                 sink_pause;
    int unsigned                 sent_count;
    int unsigned                 quiet_cycles;
    int unsigned                 error_count;
    int unsigned                 last_col;
    int unsigned                 last_row;
    logic [mpfd_pkg::DATA_W-1:0] due_byte;

    function automatic void set_dot(int unsigned col, int unsigned row);
        if (col < SCREEN_W && row < SCREEN_H)
        begin
            frame_image[(row / PAGE_ROWS) * SCREEN_W + col] |=
                mpfd_pkg::DATA_W'(8'h01 << (row % PAGE_ROWS));
        end
    endfunction

    function automatic void paint_run(int unsigned col, int unsigned row,
                                      int unsigned count, bit vertical);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (vertical)
                set_dot(col, row + i);
            else
                set_dot(col + i, row);
        end
    endfunction

    function automatic void apply_command(draw_cmd_t c);
        int unsigned col;
        int unsigned row;
        int unsigned len;
        int unsigned hgt;
        col = c.x_pos;
        row = c.y_pos;
        len = c.length;
        hgt = c.height;
        case (c.operation)
            mpfd_pkg::OP_PIXEL: set_dot(col, row);
            mpfd_pkg::OP_HLINE: paint_run(col, row, len, 1'b0);
            mpfd_pkg::OP_VLINE: paint_run(col, row, len, 1'b1);
            mpfd_pkg::OP_OUTLINE:
            begin
                paint_run(col, row, len, 1'b0);
                paint_run(col, row, hgt, 1'b1);
                paint_run(col, row + hgt, len, 1'b0);
                paint_run(col + len, row, hgt + 1, 1'b1);
            end
            mpfd_pkg::OP_FILL:
            begin
                for (int unsigned i = 0; i < hgt; i++)
                    paint_run(col, row + i, len, 1'b0);
            end
            mpfd_pkg::OP_READ:
            begin
                if (c.byte_address < STORE_BYTES)
                begin
                    readout_bytes_due.push_back(frame_image[c.byte_address]);
                    frame_image[c.byte_address] = '0;
                end
                else
                begin
                    readout_bytes_due.push_back('0);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic draw_cmd_t make_cmd(logic [mpfd_pkg::OP_W-1:0] op,
                                           int unsigned x, int unsigned y,
                                           int unsigned len, int unsigned hgt,
                                           int unsigned addr);
        draw_cmd_t c;
        c.operation    = op;
        c.x_pos        = mpfd_pkg::COORD_W'(x);
        c.y_pos        = mpfd_pkg::COORD_W'(y);
        c.length       = mpfd_pkg::COORD_W'(len);
        c.height       = mpfd_pkg::COORD_W'(hgt);
        c.byte_address = mpfd_pkg::BADDR_W'(addr);
        return c;
    endfunction

    function automatic int unsigned pick_pause();
        int unsigned roll;
        if (steady_phase)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic int unsigned random_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 90)
            return $urandom_range(12);
        else if (roll < 98)
            return $urandom_range(40);
        else
            return $urandom_range(255);
    endfunction

    function automatic draw_cmd_t random_command();
        draw_cmd_t   c;
        int unsigned pick;
        int unsigned roll;
        int unsigned col;
        int unsigned row;
        pick = $urandom_range(99);
        c.x_pos = ($urandom_range(4) == 0) ? mpfd_pkg::COORD_W'($urandom_range(255))
                                           : mpfd_pkg::COORD_W'($urandom_range(SCREEN_W - 1));
        c.y_pos = ($urandom_range(4) == 0) ? mpfd_pkg::COORD_W'($urandom_range(255))
                                           : mpfd_pkg::COORD_W'($urandom_range(SCREEN_H - 1));
        c.length       = mpfd_pkg::COORD_W'(random_size());
        c.height       = mpfd_pkg::COORD_W'(random_size());
        c.byte_address = mpfd_pkg::BADDR_W'($urandom_range(ADDR_MAX));
        if (pick < 10)
            c.operation = mpfd_pkg::OP_PIXEL;
        else if (pick < 24)
            c.operation = mpfd_pkg::OP_HLINE;
        else if (pick < 38)
            c.operation = mpfd_pkg::OP_VLINE;
        else if (pick < 50)
            c.operation = mpfd_pkg::OP_OUTLINE;
        else if (pick < 62)
            c.operation = mpfd_pkg::OP_FILL;
        else if (pick < 98)
            c.operation = mpfd_pkg::OP_READ;
        else if (pick == 98)
            c.operation = OP_SPARE_6;
        else
            c.operation = OP_SPARE_7;

        if (c.operation == mpfd_pkg::OP_READ)
        begin
            roll = $urandom_range(99);
            col  = last_col + $urandom_range(15);
            row  = last_row + $urandom_range(15);
            if (roll < 45 && col < SCREEN_W && row < SCREEN_H)
                c.byte_address = mpfd_pkg::BADDR_W'((row / PAGE_ROWS) * SCREEN_W + col);
            else if (roll < 90)
                c.byte_address = mpfd_pkg::BADDR_W'($urandom_range(STORE_BYTES - 1));
            else
                c.byte_address = mpfd_pkg::BADDR_W'($urandom_range(ADDR_MAX, STORE_BYTES));
        end
        else if (c.operation <= mpfd_pkg::OP_FILL)
        begin
            last_col = c.x_pos;
            last_row = c.y_pos;
        end
        return c;
    endfunction

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.operation    = '0;
        cmd_ch.x_pos        = '0;
        cmd_ch.y_pos        = '0;
        cmd_ch.length       = '0;
        cmd_ch.height       = '0;
        cmd_ch.byte_address = '0;
        rsp_ch.ready  = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else if (cmd_ch.valid && !cmd_taken)
        begin
        end
        else if (send_pause != 0)
        begin
            cmd_ch.valid <= 1'b0;
            send_pause   <= send_pause - 1;
        end
        else if (pending_cmds.size() != 0)
        begin
            next_cmd = pending_cmds.pop_front();
            cmd_ch.operation    <= next_cmd.operation;
            cmd_ch.x_pos        <= next_cmd.x_pos;
            cmd_ch.y_pos        <= next_cmd.y_pos;
            cmd_ch.length       <= next_cmd.length;
            cmd_ch.height       <= next_cmd.height;
            cmd_ch.byte_address <= next_cmd.byte_address;
            cmd_ch.valid        <= 1'b1;
            send_pause          <= pick_pause();
            sent_count          <= sent_count + 1;
            if (sent_count % PHASE_ITEMS == PHASE_ITEMS - 1)
                steady_phase <= ~steady_phase;
        end
        else
        begin
            cmd_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (sink_pause != 0)
        begin
            rsp_ch.ready <= 1'b0;
            sink_pause   <= sink_pause - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            sink_pause   <= pick_pause();
        end
    end

    always @(posedge clk)
    begin
        cmd_taken <= cmd_ch.valid && cmd_ch.ready;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken_cmd.operation    = cmd_ch.operation;
                taken_cmd.x_pos        = cmd_ch.x_pos;
                taken_cmd.y_pos        = cmd_ch.y_pos;
                taken_cmd.length       = cmd_ch.length;
                taken_cmd.height       = cmd_ch.height;
                taken_cmd.byte_address = cmd_ch.byte_address;
                apply_command(taken_cmd);
            end

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (readout_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected read_data item, expected none, got %02h",
                             $time, rsp_ch.read_data);
                    error_count++;
                end
                else
                begin
                    due_byte = readout_bytes_due.pop_front();
                    if (rsp_ch.read_data !== due_byte)
                    begin
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, due_byte, rsp_ch.read_data);
                        error_count++;
                    end
                end
            end

            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_taken    = 1'b0;
        steady_phase = 1'b0;
        send_pause   = 0;
        sink_pause   = 0;
        sent_count   = 0;
        quiet_cycles = 0;
        error_count  = 0;
        last_col     = 0;
        last_row     = 0;
        foreach (frame_image[i])
            frame_image[i] = '0;

        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_PIXEL, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_PIXEL, SCREEN_W - 1, SCREEN_H - 1,
                                        0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_PIXEL, SCREEN_W, 5, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_PIXEL, 5, SCREEN_H, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_PIXEL, 255, 255, 255, 255, ADDR_MAX));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, STORE_BYTES - 1));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, 5));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_HLINE, 230, 9, 20, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_HLINE, 10, 10, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_VLINE, 3, 2, 255, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_VLINE, 4, 4, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, SCREEN_W + 3));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, SCREEN_W + 235));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_OUTLINE, 50, 20, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_OUTLINE, 100, 60, 30, 17, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_OUTLINE, 220, 150, 255, 255, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_FILL, 60, 100, 8, 0, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_FILL, 200, 150, 255, 255, 0));
        pending_cmds.push_back(make_cmd(OP_SPARE_6, 255, 255, 255, 255, ADDR_MAX));
        pending_cmds.push_back(make_cmd(OP_SPARE_7, 255, 255, 255, 255, 0));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, STORE_BYTES));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 255, 255, 255, 255, ADDR_MAX));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, 2 * SCREEN_W + 50));
        pending_cmds.push_back(make_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, STORE_BYTES - 1));

        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_cmds.push_back(random_command());

        @(posedge rst_n);
        while (pending_cmds.size() != 0 || cmd_ch.valid || readout_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && readout_bytes_due.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            if (readout_bytes_due.size() != 0)
                $display("%0t: %0d read_data items never arrived", $time,
                         readout_bytes_due.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/mpfd_pkg.sv
sv/mpfd_cmd_if.sv
sv/mpfd_rsp_if.sv
sv/mpfd_ram.sv
sv/mono_page_framebuffer_draw_unit.sv
tb/sv/testbench.sv
